// File: rtl/core/s224_pkg.sv
// Shared types, constants and tables for the SHA-224 stream hasher.
// Used by s224_round and sha224_stream_hasher; depends on nothing else.
package s224_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned MsgDepth = 16;
  localparam int unsigned CvDepth  = 8;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned DigWords = 7;

  localparam logic [7:0] PadMark = 8'h80;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD_MARK,
    ST_PAD_FILL,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_DIG_RD,
    ST_DIG_OUT
  } state_e;

  typedef struct packed {
    logic load;   // shift a chaining word into the working variables
    logic round;  // run one compression round
    logic w_mem;  // round word comes from the message memory
    logic rot;    // rotate working variables during the final addition
  } rnd_ctrl_t;

  localparam logic [WordW-1:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitHash [CvDepth] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

endpackage

// File: rtl/core/sha224_stream_hasher.sv
// SHA-224 stream hasher top level: byte packing, padding and block sequencing.
// Depends on s224_pkg, s224_ram and s224_round.
// Accepts one byte item per cycle while idle; input stalls while each full 64-byte block is
// processed: chaining loads, the compression rounds, read-modify-write additions on the chaining RAM.
// Final item: up to 18 padding writes, one or two blocks, then 7 digest words, each read from
// the registered RAM port and held until taken. After reset and after each digest a pass rewrites
// the initial hash into the chaining RAM while no item is accepted.
module sha224_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser_o,   // [2:0] word_index
  output logic        m_axis_tlast_o
);

  localparam int unsigned MsgDepth = s224_pkg::MsgDepth;
  localparam int unsigned CvDepth  = s224_pkg::CvDepth;
  localparam int unsigned W   = s224_pkg::WordW;
  localparam int unsigned MaW = $clog2(MsgDepth);
  localparam int unsigned CaW = $clog2(CvDepth);

  s224_pkg::state_e state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] wacc_q, wacc_d;
  logic [60:0] nbytes_q, nbytes_d;
  logic        eom_q, eom_d, pad_q, pad_d, extra_q, extra_d;
  logic [4:0]  widx_q, widx_d;

  logic           msg_we, msg_re;
  logic [MaW-1:0] msg_waddr, msg_raddr;
  logic [W-1:0]   msg_wdata, msg_rdata;
  logic           cv_we, cv_re;
  logic [CaW-1:0] cv_waddr, cv_raddr;
  logic [W-1:0]   cv_wdata, cv_rdata;

  s224_pkg::rnd_ctrl_t ctrl;
  logic [W-1:0] wv_head;
  logic [6:0]   rnd_idx, cnt_m1;
  logic         accept;
  logic [4:0]   shift;
  logic [31:0]  byte_word, mark_word, base_word;
  logic [4:0]   fill_lim;
  logic [63:0]  bit_len;

  assign accept    = s_axis_tvalid_i & s_axis_tready_o;
  assign shift     = {~pos_q[1:0], 3'b000};
  assign base_word = (pos_q[1:0] == 2'd0) ? 32'd0 : wacc_q;
  assign byte_word = base_word | (32'(s_axis_tdata_i) << shift);
  assign mark_word = base_word | (32'(s224_pkg::PadMark) << shift);
  assign fill_lim  = extra_q ? 5'd16 : 5'd14;
  assign bit_len   = {nbytes_q, 3'b000};
  assign cnt_m1    = cnt_q - 7'd1;
  assign rnd_idx   = cnt_m1;
  assign cv_wdata  = (state_q == s224_pkg::ST_INIT) ? s224_pkg::InitHash[cnt_q[CaW-1:0]]
                                                    : cv_rdata + wv_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= s224_pkg::ST_INIT;
      cnt_q    <= '0;
      pos_q    <= '0;
      nbytes_q <= '0;
      eom_q    <= 1'b0;
      pad_q    <= 1'b0;
      extra_q  <= 1'b0;
      widx_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      nbytes_q <= nbytes_d;
      eom_q    <= eom_d;
      pad_q    <= pad_d;
      extra_q  <= extra_d;
      widx_q   <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wacc_q <= wacc_d;
  end

  // Next state and sequencing registers.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    wacc_d   = wacc_q;
    nbytes_d = nbytes_q;
    eom_d    = eom_q;
    pad_d    = pad_q;
    extra_d  = extra_q;
    widx_d   = widx_q;
    unique case (state_q)
      s224_pkg::ST_INIT: begin
        pos_d    = '0;
        nbytes_d = '0;
        eom_d    = 1'b0;
        pad_d    = 1'b0;
        extra_d  = 1'b0;
        cnt_d    = cnt_q + 7'd1;
        if (cnt_q == 7'(CvDepth - 1)) begin
          cnt_d   = '0;
          state_d = s224_pkg::ST_IDLE;
        end
      end
      s224_pkg::ST_IDLE: begin
        if (accept) begin
          eom_d = s_axis_tlast_i;
          if (s_axis_tuser_i) begin
            wacc_d   = byte_word;
            pos_d    = pos_q + 6'd1;
            nbytes_d = nbytes_q + 61'd1;
          end
          cnt_d = '0;
          if (s_axis_tuser_i && pos_q == 6'd63) begin
            state_d = s224_pkg::ST_LOAD;
          end else if (s_axis_tlast_i) begin
            state_d = s224_pkg::ST_PAD_MARK;
          end
        end
      end
      s224_pkg::ST_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(CvDepth)) begin
          cnt_d   = '0;
          state_d = s224_pkg::ST_ROUND;
        end
      end
      s224_pkg::ST_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(s224_pkg::Rounds)) begin
          cnt_d   = '0;
          state_d = s224_pkg::ST_ADD;
        end
      end
      s224_pkg::ST_ADD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(CvDepth)) begin
          cnt_d = '0;
          priority if (pad_q && extra_q) begin
            extra_d = 1'b0;
            widx_d  = '0;
            state_d = s224_pkg::ST_PAD_FILL;
          end else if (pad_q) begin
            state_d = s224_pkg::ST_DIG_RD;
          end else if (eom_q) begin
            state_d = s224_pkg::ST_PAD_MARK;
          end else begin
            state_d = s224_pkg::ST_IDLE;
          end
        end
      end
      s224_pkg::ST_PAD_MARK: begin
        pad_d   = 1'b1;
        widx_d  = {1'b0, pos_q[5:2]} + 5'd1;
        extra_d = (pos_q[5:3] == 3'b111);
        state_d = s224_pkg::ST_PAD_FILL;
      end
      s224_pkg::ST_PAD_FILL: begin
        if (widx_q < fill_lim) begin
          widx_d = widx_q + 5'd1;
        end else if (extra_q) begin
          cnt_d   = '0;
          state_d = s224_pkg::ST_LOAD;
        end else begin
          state_d = s224_pkg::ST_LEN_HI;
        end
      end
      s224_pkg::ST_LEN_HI: state_d = s224_pkg::ST_LEN_LO;
      s224_pkg::ST_LEN_LO: begin
        cnt_d   = '0;
        state_d = s224_pkg::ST_LOAD;
      end
      s224_pkg::ST_DIG_RD: state_d = s224_pkg::ST_DIG_OUT;
      s224_pkg::ST_DIG_OUT: begin
        if (m_axis_tready_i) begin
          if (cnt_q == 7'(s224_pkg::DigWords - 1)) begin
            cnt_d   = '0;
            state_d = s224_pkg::ST_INIT;
          end else begin
            cnt_d   = cnt_q + 7'd1;
            state_d = s224_pkg::ST_DIG_RD;
          end
        end
      end
      default: state_d = s224_pkg::ST_INIT;
    endcase
  end

  // Memory ports and datapath control. The addition reads entry n while it
  // writes entry n-1, so read and write never meet on one entry.
  always_comb begin
    msg_we          = 1'b0;
    msg_waddr       = '0;
    msg_wdata       = '0;
    msg_re          = 1'b0;
    msg_raddr       = cnt_q[MaW-1:0];
    cv_we           = 1'b0;
    cv_waddr        = cnt_q[CaW-1:0];
    cv_re           = 1'b0;
    cv_raddr        = cnt_q[CaW-1:0];
    ctrl            = '0;
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;
    unique case (state_q)
      s224_pkg::ST_INIT: cv_we = 1'b1;
      s224_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        msg_we    = accept && s_axis_tuser_i && (pos_q[1:0] == 2'd3);
        msg_waddr = pos_q[5:2];
        msg_wdata = byte_word;
      end
      s224_pkg::ST_LOAD: begin
        cv_re     = (cnt_q < 7'(CvDepth));
        ctrl.load = (cnt_q != 7'd0);
      end
      s224_pkg::ST_ROUND: begin
        msg_re     = (cnt_q < 7'(MsgDepth));
        ctrl.round = (cnt_q != 7'd0);
        ctrl.w_mem = (cnt_q <= 7'(MsgDepth));
      end
      s224_pkg::ST_ADD: begin
        cv_re    = (cnt_q < 7'(CvDepth));
        cv_we    = (cnt_q != 7'd0);
        cv_waddr = cnt_m1[CaW-1:0];
        ctrl.rot = (cnt_q != 7'd0);
      end
      s224_pkg::ST_PAD_MARK: begin
        msg_we    = 1'b1;
        msg_waddr = pos_q[5:2];
        msg_wdata = mark_word;
      end
      s224_pkg::ST_PAD_FILL: begin
        msg_we    = (widx_q < fill_lim);
        msg_waddr = widx_q[MaW-1:0];
      end
      s224_pkg::ST_LEN_HI: begin
        msg_we    = 1'b1;
        msg_waddr = MaW'(MsgDepth - 2);
        msg_wdata = bit_len[63:32];
      end
      s224_pkg::ST_LEN_LO: begin
        msg_we    = 1'b1;
        msg_waddr = MaW'(MsgDepth - 1);
        msg_wdata = bit_len[31:0];
      end
      s224_pkg::ST_DIG_RD: cv_re = 1'b1;
      s224_pkg::ST_DIG_OUT: m_axis_tvalid_o = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata_o = cv_rdata;
  assign m_axis_tuser_o = cnt_q[2:0];
  assign m_axis_tlast_o = (cnt_q == 7'(s224_pkg::DigWords - 1));

  s224_ram #(.Width(W), .Depth(MsgDepth)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_waddr),
    .wdata_i (msg_wdata),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  s224_ram #(.Width(W), .Depth(CvDepth)) u_cv_ram (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .waddr_i (cv_waddr),
    .wdata_i (cv_wdata),
    .re_i    (cv_re),
    .raddr_i (cv_raddr),
    .rdata_o (cv_rdata)
  );

  s224_round u_round (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .k_i         (s224_pkg::RoundK[rnd_idx[5:0]]),
    .msg_rdata_i (msg_rdata),
    .cv_rdata_i  (cv_rdata),
    .wv_head_o   (wv_head)
  );

endmodule

// File: rtl/core/s224_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
// Generic storage used for the message words and the chaining value.
module s224_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/s224_round.sv
// SHA-224 round datapath: working variables and the 16-word expansion window.
// Depends on s224_pkg for the control struct and word width.
module s224_round (
  input  logic                       clk_i,
  input  s224_pkg::rnd_ctrl_t        ctrl_i,
  input  logic [s224_pkg::WordW-1:0] k_i,
  input  logic [s224_pkg::WordW-1:0] msg_rdata_i,
  input  logic [s224_pkg::WordW-1:0] cv_rdata_i,
  output logic [s224_pkg::WordW-1:0] wv_head_o
);

  localparam int unsigned W = s224_pkg::WordW;

  function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (W - n));
  endfunction

  logic [W-1:0] wv_q [8];
  logic [W-1:0] sw_q [16];

  logic [W-1:0] s0, s1, big_s0, big_s1, ch, maj, w_exp, w_cur, t1, t2;

  always_comb begin
    s1     = rotr(sw_q[14], 17) ^ rotr(sw_q[14], 19) ^ (sw_q[14] >> 10);
    s0     = rotr(sw_q[1], 7) ^ rotr(sw_q[1], 18) ^ (sw_q[1] >> 3);
    w_exp  = s1 + sw_q[9] + s0 + sw_q[0];
    w_cur  = ctrl_i.w_mem ? msg_rdata_i : w_exp;
    big_s1 = rotr(wv_q[4], 6) ^ rotr(wv_q[4], 11) ^ rotr(wv_q[4], 25);
    big_s0 = rotr(wv_q[0], 2) ^ rotr(wv_q[0], 13) ^ rotr(wv_q[0], 22);
    ch     = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
    maj    = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
    t1     = wv_q[7] + big_s1 + ch + k_i + w_cur;
    t2     = big_s0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      for (int i = 0; i < 7; i++) wv_q[i] <= wv_q[i+1];
      wv_q[7] <= cv_rdata_i;
    end else if (ctrl_i.rot) begin
      for (int i = 0; i < 7; i++) wv_q[i] <= wv_q[i+1];
      wv_q[7] <= wv_q[0];
    end else if (ctrl_i.round) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  // The window always holds the last sixteen round words, newest at the top.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.round) begin
      for (int i = 0; i < 15; i++) sw_q[i] <= sw_q[i+1];
      sw_q[15] <= w_cur;
    end
  end

  assign wv_head_o = wv_q[0];

endmodule
